### rtl/euler_to_quaternion_macros.svh
// Assertion macros for the euler_to_quaternion checker
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH
// implication checked on every clock, skipped in reset
`define E2Q_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("e2q check failed");
// next-cycle implication
`define E2Q_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("e2q check failed");
`endif

### rtl/e2q_pkg.sv
// Package: fixed-point constants and the arctangent table for euler_to_quaternion
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;
    localparam int TAB_LEN = 32;
    localparam int TAB_FRAC = 30;
    localparam logic signed [33:0] GAIN_Q30 = 34'sh026DD3B6A;
    localparam int DP_W = 34;   // Q2.30 plus headroom for CORDIC growth
    localparam int OUT_W = 16;
    localparam logic signed [OUT_W-1:0] Q_ONE = 16'sd16384;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] t [0:TAB_LEN-1];
        t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
              32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
              32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
              32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
              32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
              32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
              32'h00000000, 32'h00000000};
        return t[i];
    endfunction

    // Q30 value rounded half up to Q2.F, F = ang_frac (< 30)
    function automatic longint to_ang(input longint q30, input int ang_frac);
        longint sh;
        sh = TAB_FRAC - ang_frac;
        return (q30 + (longint'(1) << (sh - 1))) >>> sh;
    endfunction
endpackage
`default_nettype wire

### rtl/e2q_cordic.sv
// Pipelined rotation-mode CORDIC: cosine and sine of half an angle, one stage per step
`timescale 1ns / 1ps
`default_nettype none
module e2q_cordic #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [15:0]            angle,
    output logic signed [e2q_pkg::DP_W-1:0]    cos_out,
    output logic signed [e2q_pkg::DP_W-1:0]    sin_out
);
    import e2q_pkg::*;
    localparam int AF = ANGLE_BITS - 3;
    localparam int NS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int ZW = ANGLE_BITS + 2;
    localparam longint HALF_PI = to_ang(2 * longint'(atan_q30(0)), AF);
    localparam longint PI_A    = to_ang(4 * longint'(atan_q30(0)), AF);

    logic signed [ZW-1:0]   z_reg [0:NS];
    logic signed [DP_W-1:0] x_reg [0:NS];
    logic signed [DP_W-1:0] y_reg [0:NS];
    logic                   neg_reg [0:NS];

    // stage 0: scale and fold
    logic signed [ZW+15:0] z_wide;
    logic signed [ZW-1:0]  z0;
    always_comb begin
        if (AF >= 14) begin
            z_wide = (ZW+16)'(angle) <<< (AF >= 14 ? AF - 14 : 0);
        end else begin
            z_wide = ((ZW+16)'(angle) + ((ZW+16)'(1) <<< (AF < 14 ? 13 - AF : 0)))
                     >>> (AF < 14 ? 14 - AF : 0);
        end
        z0 = ZW'(z_wide);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= GAIN_Q30;
            y_reg[0] <= '0;
            if (64'(z0) > HALF_PI) begin
                z_reg[0] <= ZW'(PI_A) - z0;
                neg_reg[0] <= 1'b1;
            end else if (64'(z0) < -HALF_PI) begin
                z_reg[0] <= -ZW'(PI_A) - z0;
                neg_reg[0] <= 1'b1;
            end else begin
                z_reg[0] <= z0;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_step
        localparam logic signed [ZW-1:0] T = ZW'(to_ang(longint'(atan_q30(i)), AF));
        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][ZW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - T;
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + T;
                end
            end
        end
    end

    assign cos_out = neg_reg[NS] ? -x_reg[NS] : x_reg[NS];
    assign sin_out = y_reg[NS];
endmodule
`default_nettype wire

### rtl/e2q_combine.sv
// Quaternion products: pair stage, triple stage, round and saturate stage
`timescale 1ns / 1ps
`default_nettype none
module e2q_combine (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [e2q_pkg::DP_W-1:0] cy,
    input  wire logic signed [e2q_pkg::DP_W-1:0] sy,
    input  wire logic signed [e2q_pkg::DP_W-1:0] cp,
    input  wire logic signed [e2q_pkg::DP_W-1:0] sp,
    input  wire logic signed [e2q_pkg::DP_W-1:0] cr,
    input  wire logic signed [e2q_pkg::DP_W-1:0] sr,
    output logic signed [e2q_pkg::OUT_W-1:0]   qw,
    output logic signed [e2q_pkg::OUT_W-1:0]   qx,
    output logic signed [e2q_pkg::OUT_W-1:0]   qy,
    output logic signed [e2q_pkg::OUT_W-1:0]   qz
);
    import e2q_pkg::*;
    localparam int PW = 2 * DP_W;
    localparam int SW = PW + 1;

    // stage A: registered inputs
    logic signed [DP_W-1:0] cy_reg, sy_reg, cp_reg, sp_reg, cr_a_reg, sr_a_reg;
    // stage B: pair products rounded to Q30
    logic signed [DP_W-1:0] cycp_reg, sysp_reg, sycp_reg, cysp_reg, cr_b_reg, sr_b_reg;
    // stage C: triple products
    logic signed [PW-1:0] p_reg [0:7];
    // stage D: sums
    logic signed [SW-1:0] s_reg [0:3];

    function automatic logic signed [DP_W-1:0] mul30(input logic signed [DP_W-1:0] a,
                                                      input logic signed [DP_W-1:0] b);
        logic signed [PW-1:0] p;
        p = (PW'(a) * PW'(b)) + (PW'(1) <<< (TAB_FRAC - 1));
        return DP_W'(p >>> TAB_FRAC);
    endfunction

    function automatic logic signed [OUT_W-1:0] fin(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + (SW'(1) <<< 45)) >>> 46;
        if (r > SW'(Q_ONE)) return Q_ONE;
        if (r < -SW'(Q_ONE)) return -Q_ONE;
        return OUT_W'(r);
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            cy_reg <= cy; sy_reg <= sy; cp_reg <= cp; sp_reg <= sp;
            cr_a_reg <= cr; sr_a_reg <= sr;
            cycp_reg <= mul30(cy_reg, cp_reg);
            sysp_reg <= mul30(sy_reg, sp_reg);
            sycp_reg <= mul30(sy_reg, cp_reg);
            cysp_reg <= mul30(cy_reg, sp_reg);
            cr_b_reg <= cr_a_reg; sr_b_reg <= sr_a_reg;
            p_reg[0] <= PW'(cycp_reg) * PW'(cr_b_reg);
            p_reg[1] <= PW'(sysp_reg) * PW'(sr_b_reg);
            p_reg[2] <= PW'(cycp_reg) * PW'(sr_b_reg);
            p_reg[3] <= PW'(sysp_reg) * PW'(cr_b_reg);
            p_reg[4] <= PW'(sycp_reg) * PW'(sr_b_reg);
            p_reg[5] <= PW'(cysp_reg) * PW'(cr_b_reg);
            p_reg[6] <= PW'(sycp_reg) * PW'(cr_b_reg);
            p_reg[7] <= PW'(cysp_reg) * PW'(sr_b_reg);
            s_reg[0] <= SW'(p_reg[0]) + SW'(p_reg[1]);
            s_reg[1] <= SW'(p_reg[2]) - SW'(p_reg[3]);
            s_reg[2] <= SW'(p_reg[4]) + SW'(p_reg[5]);
            s_reg[3] <= SW'(p_reg[6]) - SW'(p_reg[7]);
            qw <= fin(s_reg[0]);
            qx <= fin(s_reg[1]);
            qy <= fin(s_reg[2]);
            qz <= fin(s_reg[3]);
        end
    end
endmodule
`default_nettype wire

### rtl/euler_to_quaternion.sv
// Top level: Z-Y-X Euler angles to unit quaternion, fully pipelined
`timescale 1ns / 1ps
`default_nettype none
// Converts yaw/pitch/roll (signed Q2.13 rad) to quaternion w,x,y,z (signed
// Q1.14, saturated to +-1). Each half angle goes through its own pipelined
// CORDIC, one register stage per iteration, then pair products, triple
// products, sums and round/saturate each take a stage. Throughput is one item
// per cycle while the output is not stalled; depth is set by the CORDIC stage
// count (steps capped at 32). The pipeline advances as one unit whenever the
// last stage is empty or its item is being taken, so a stall holds every item
// in place. s_ready stays low while in reset. No state is kept between items.
module euler_to_quaternion #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_yaw_angle,
    input  wire logic signed [15:0] s_pitch_angle,
    input  wire logic signed [15:0] s_roll_angle,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_quat_w,
    output logic signed [15:0]      m_quat_x,
    output logic signed [15:0]      m_quat_y,
    output logic signed [15:0]      m_quat_z
);
    import e2q_pkg::*;
    localparam int NS  = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int LAT = NS + 6;   // fold stage, NS steps, 5 combine stages

    logic en;
    logic [LAT-1:0] vld_reg;
    logic signed [DP_W-1:0] cy, sy, cp, sp, cr, sr;

    // global advance: free when the output slot is empty or draining
    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en && aresetn;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .aclk(aclk), .en(en), .angle(s_yaw_angle), .cos_out(cy), .sin_out(sy));
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .aclk(aclk), .en(en), .angle(s_pitch_angle), .cos_out(cp), .sin_out(sp));
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .aclk(aclk), .en(en), .angle(s_roll_angle), .cos_out(cr), .sin_out(sr));

    e2q_combine u_comb (
        .aclk(aclk), .en(en),
        .cy(cy), .sy(sy), .cp(cp), .sp(sp), .cr(cr), .sr(sr),
        .qw(m_quat_w), .qx(m_quat_x), .qy(m_quat_y), .qz(m_quat_z));
endmodule
`default_nettype wire

### rtl/e2q_checker.sv
// Port-level checker for euler_to_quaternion and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "euler_to_quaternion_macros.svh"
module e2q_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_quat_w,
    input wire logic signed [15:0] m_quat_x
);
    `E2Q_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    `E2Q_ASSERT_IMP(a_w_range, aclk, aresetn, m_valid, m_quat_w <= 16384 && m_quat_w >= -16384)
    `E2Q_ASSERT_IMP(a_x_range, aclk, aresetn, m_valid, m_quat_x <= 16384 && m_quat_x >= -16384)
    `E2Q_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_quat_w))
endmodule
bind euler_to_quaternion e2q_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_quat_w(m_quat_w), .m_quat_x(m_quat_x));
`default_nettype wire

### bench/tb_top.sv
// Testbench for euler_to_quaternion: random and corner angles checked against a CORDIC predictor
`timescale 1ns / 1ps
`default_nettype none

// Holds predicted quaternions in order and compares them with what the block returns.
class quat_scoreboard;
    typedef struct packed {
        logic signed [15:0] w, x, y, z;
    } quat_t;

    quat_t pending[$];
    int mismatches;
    int checked;

    // round half up, built on the floor shift of >>> on longint
    static function longint round_sh(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    static function longint tab_ang(longint q30);
        return round_sh(q30, 30 - 13);
    endfunction

    // cosine and sine (Q2.30) of half the Q2.13 angle
    static function void half_cs(logic signed [15:0] ang, output longint c, output longint s);
        longint z, x, y, hp, pi_a, xs, ys, t;
        bit flip;
        z = round_sh(longint'(ang), 1);   // Q2.14 half angle to Q2.13
        hp = tab_ang(2 * longint'(e2q_pkg::atan_q30(0)));
        pi_a = tab_ang(4 * longint'(e2q_pkg::atan_q30(0)));
        flip = 0;
        if (z > hp) begin
            z = pi_a - z;
            flip = 1;
        end else if (z < -hp) begin
            z = -pi_a - z;
            flip = 1;
        end
        x = 64'h26DD3B6A;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            t = tab_ang(longint'(e2q_pkg::atan_q30(i)));
            if (z >= 0) begin
                x -= ys; y += xs; z -= t;
            end else begin
                x += ys; y -= xs; z += t;
            end
        end
        c = flip ? -x : x;
        s = y;
    endfunction

    static function logic signed [15:0] sum_sat(longint p, longint q, bit add);
        longint v;
        v = round_sh(add ? p + q : p - q, 46);
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    function void note_angles(logic signed [15:0] yaw, logic signed [15:0] pitch,
                              logic signed [15:0] roll);
        longint cy, sy, cp, sp, cr, sr, cycp, sysp, sycp, cysp;
        quat_t q;
        half_cs(yaw, cy, sy);
        half_cs(pitch, cp, sp);
        half_cs(roll, cr, sr);
        cycp = round_sh(cy * cp, 30);
        sysp = round_sh(sy * sp, 30);
        sycp = round_sh(sy * cp, 30);
        cysp = round_sh(cy * sp, 30);
        q.w = sum_sat(cycp * cr, sysp * sr, 1);
        q.x = sum_sat(cycp * sr, sysp * cr, 0);
        q.y = sum_sat(sycp * sr, cysp * cr, 1);
        q.z = sum_sat(sycp * cr, cysp * sr, 0);
        pending = {pending, q};
    endfunction

    function void check_quat(quat_t got);
        quat_t exp_q;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        exp_q = pending.pop_front();
        if (exp_q !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("quat mismatch: exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                         exp_q.w, exp_q.x, exp_q.y, exp_q.z, got.w, got.x, got.y, got.z);
        end
    endfunction
endclass

module tb_top;
    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic signed [15:0] s_yaw_angle, s_pitch_angle, s_roll_angle;
    logic signed [15:0] m_quat_w, m_quat_x, m_quat_y, m_quat_z;

    quat_scoreboard sb;
    int sent;
    bit stall_hold;     // receiver long hold-off in progress
    bit no_idle;        // stretch with no idling on either side

    euler_to_quaternion uut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // send one item; sender may idle before it
    task automatic send_angles(logic signed [15:0] yaw, logic signed [15:0] pitch,
                               logic signed [15:0] roll);
        if (!no_idle && $urandom_range(99) < 36) begin
            s_valid <= 0;
            do @(posedge aclk); while (!no_idle && $urandom_range(99) < 36);
        end
        s_valid <= 1;
        s_yaw_angle <= yaw;
        s_pitch_angle <= pitch;
        s_roll_angle <= roll;
        // wait for acceptance; predict on the accepting edge
        do @(posedge aclk); while (!s_ready);
        sb.note_angles(yaw, pitch, roll);
        sent++;
    endtask

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            // near the fold points at +-pi (half angle +-pi/2)
            2: return $urandom_range(1) ? 16'(25736 + int'($urandom_range(8)) - 4)
                                        : 16'(-25736 + int'($urandom_range(8)) - 4);
            3: return 16'(int'($urandom_range(16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver ready: random idling, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 0;
        else
            m_ready <= !stall_hold && (no_idle || $urandom_range(99) >= 36);
    end

    // results are sampled at the edge where valid and ready meet
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_quat({m_quat_w, m_quat_x, m_quat_y, m_quat_z});
    end

    // long receiver stall, counted in cycles here, while the sender keeps offering
    initial begin
        stall_hold = 0;
        wait (sent == 60);
        stall_hold = 1;
        repeat (120) @(posedge aclk);
        stall_hold = 0;
    end

    initial begin
        logic signed [15:0] corners [6] = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, -16'sd1,
                                           16'sd12868};
        sb = new();
        sent = 0;
        no_idle = 0;
        aresetn = 0;
        s_valid = 0;
        s_yaw_angle = 0;
        s_pitch_angle = 0;
        s_roll_angle = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, zero, small, and fold boundaries on each axis
        foreach (corners[i]) send_angles(corners[i], corners[(i + 1) % 6], corners[(i + 2) % 6]);
        send_angles(16'sd25736, -16'sd25736, 16'sd25737);
        send_angles(-16'sd25737, 16'sd25735, -16'sd25735);
        send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_angles(16'sh8000, 16'sh8000, 16'sh8000);
        send_angles(16'sh5555, 16'shAAAA, 16'sh0F0F);
        send_angles(16'shAAAA, 16'sh5555, 16'shF0F0);

        for (int n = 0; n < 440; n++) begin
            no_idle = (n >= 200 && n < 280);
            send_angles(pick_angle(), pick_angle(), pick_angle());
        end
        s_valid <= 0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("ran %0d orientations through, %0d quaternions checked, %0d mismatches",
                 sent, sb.checked, sb.mismatches);
        $display("covered angle extremes, half-angle fold points, stalls and back pressure");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
